// File: sv/gpea_pkg.sv
// Shared types and constants for the gamepad edge and auto-repeat block.
// Used by the datapath, the controller, the top level and the checker.
package gpea_pkg;

  localparam int BTN_W = 16;
  localparam int CNT_W = 16;
  localparam int CTL_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FAST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STICK = 2'd3;

  localparam logic [CNT_W-1:0] DELAY_RESET = 16'd20;
  localparam logic [CNT_W-1:0] PERIOD_RESET = 16'd4;

  localparam logic [BTN_W-1:0] PAD_UP = 16'h0800;
  localparam logic [BTN_W-1:0] PAD_DOWN = 16'h0400;
  localparam logic [BTN_W-1:0] PAD_LEFT = 16'h0200;
  localparam logic [BTN_W-1:0] PAD_RIGHT = 16'h0100;

  typedef struct packed {
    logic              operation;
    logic [CTL_W-1:0]  controller;
    logic [BTN_W-1:0]  buttons;
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
  } in_t;

  typedef struct packed {
    logic [CTL_W-1:0] port;
    logic [BTN_W-1:0] held;
    logic [BTN_W-1:0] pressed_edge;
    logic [BTN_W-1:0] repeat_pulse;
  } out_t;

  typedef struct packed {
    logic load;
    logic fast_wr;
    logic rd;
    logic upd;
    logic div_step;
    logic next_b;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic port_ok;
    logic op_fast;
    logic mask_nz;
    logic need_div;
    logic div_last;
    logic last_b;
    logic out_free;
  } sts_t;

endpackage

// File: sv/gamepad_edge_and_autorepeat.sv
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    gpea_pkg::in_t  (operation, controller, buttons, stick)
// out      out  out_valid/out_ready  gpea_pkg::out_t (port, held, pressed_edge, repeat_pulse)
// cfg      in   cfg_we               cfg_index, cfg_data (64 bits)
//
// A frame sample runs the 16-step remainder unit for each enabled held button whose count
// lies past the delay by a period or more.
// A fast-set or an ignored controller goes back to idle from dispatch with no result.
// Reset sets config to its defaults and clears previous buttons and counter valid bits.
// A result waits in the output register; the next item is taken while it waits,
// and the sequencer holds before emit until the register is free.
module gamepad_edge_and_autorepeat #(
  parameter int NUM_CONTROLLERS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gpea_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gpea_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [gpea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gpea_pkg::CFG_DATA_W-1:0] cfg_data
);

  gpea_pkg::cmd_t cmd;
  gpea_pkg::sts_t sts;

  gpea_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gpea_dp #(
    .NUM_CONTROLLERS (NUM_CONTROLLERS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: sv/gpea_dp.sv
// Datapath: config registers, hold counter memory, remainder unit, result register.
// Depends on gpea_pkg; driven by gpea_ctrl through cmd_t, reports through sts_t.
module gpea_dp #(
  parameter int NUM_CONTROLLERS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gpea_pkg::in_t                       in_data,
  input  logic                                cfg_we,
  input  logic [gpea_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gpea_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  gpea_pkg::cmd_t                      cmd,
  output gpea_pkg::sts_t                      sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gpea_pkg::out_t                      out_data
);

  localparam int DEPTH = 16 * NUM_CONTROLLERS;
  localparam int AW = $clog2(DEPTH);
  localparam int PW = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;
  localparam logic [2:0] NC = 3'(NUM_CONTROLLERS);

  logic [15:0] cfg_delay;
  logic [15:0] cfg_period;
  logic [63:0] cfg_mask;
  logic        cfg_stick;

  logic        op_q;
  logic [1:0]  c_q;
  logic [15:0] held_q;
  logic [3:0]  b_q;
  logic [15:0] pulse_q;

  logic [15:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [15:0] mem_q;
  logic        vld_q;

  logic [15:0] div_dq;
  logic [15:0] div_rem;
  logic [3:0]  div_cnt;

  logic [15:0] prev [NUM_CONTROLLERS];

  logic [8:0]  sx, sy, ax, ay;
  logic [15:0] stick_bits, held_in;
  logic [3:0]  lsb;
  logic [5:0]  rd_full, fast_full;
  logic [AW-1:0] rd_addr, wr_addr;
  logic        wr_en;
  logic [15:0] wr_data, fast_val;
  logic [15:0] en, cnt, cnt_new, d;
  logic        hit, ge_delay, imm_pulse;
  logic [16:0] div_t, div_sub;
  logic [15:0] rem_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_delay <= gpea_pkg::DELAY_RESET;
      cfg_period <= gpea_pkg::PERIOD_RESET;
      cfg_mask <= '0;
      cfg_stick <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gpea_pkg::CFG_DELAY: cfg_delay <= cfg_data[15:0];
        gpea_pkg::CFG_PERIOD: cfg_period <= cfg_data[15:0];
        gpea_pkg::CFG_ENABLE: cfg_mask <= cfg_data;
        gpea_pkg::CFG_STICK: cfg_stick <= cfg_data[0];
      endcase
    end
  end

  always_comb begin
    sx = {in_data.stick_x[7], in_data.stick_x};
    sy = {in_data.stick_y[7], in_data.stick_y};
    ax = sx[8] ? (~sx + 9'd1) : sx;
    ay = sy[8] ? (~sy + 9'd1) : sy;
    stick_bits = '0;
    if (ay >= ax) begin
      if (in_data.stick_y >= 8'sd8) stick_bits = stick_bits | gpea_pkg::PAD_UP;
      if (in_data.stick_y <= -8'sd8) stick_bits = stick_bits | gpea_pkg::PAD_DOWN;
    end else begin
      if (in_data.stick_x <= -8'sd8) stick_bits = stick_bits | gpea_pkg::PAD_LEFT;
      if (in_data.stick_x >= 8'sd8) stick_bits = stick_bits | gpea_pkg::PAD_RIGHT;
    end
    held_in = in_data.buttons | (cfg_stick ? stick_bits : 16'h0000);
  end

  always_comb begin
    lsb = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (held_q[i]) lsb = 4'(i);
    end
  end

  assign rd_full = {c_q, b_q};
  assign fast_full = {c_q, lsb};
  assign rd_addr = rd_full[AW-1:0];
  assign wr_addr = cmd.fast_wr ? fast_full[AW-1:0] : rd_addr;
  assign fast_val = cfg_delay + cfg_period - 16'd1;

  assign en = cfg_mask[{c_q, 4'b0000} +: 16];
  assign cnt = vld_q ? mem_q : 16'h0000;
  assign cnt_new = held_q[b_q] ? (cnt + 16'd1) : 16'h0000;
  assign hit = en[b_q] && held_q[b_q];
  assign ge_delay = cnt_new >= cfg_delay;
  assign d = cnt_new - cfg_delay;
  assign imm_pulse = hit && ((cnt_new == 16'd1) || (ge_delay && d == 16'h0000));

  assign wr_en = cmd.fast_wr || (cmd.upd && en[b_q]);
  assign wr_data = cmd.fast_wr ? fast_val : cnt_new;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) begin
      mem_q <= mem[rd_addr];
      vld_q <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  assign div_t = {div_rem, div_dq[15]};
  assign div_sub = div_t - {1'b0, cfg_period};
  assign rem_next = (div_t >= {1'b0, cfg_period}) ? div_sub[15:0] : div_t[15:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= in_data.operation;
      c_q <= in_data.controller;
      held_q <= (in_data.operation == gpea_pkg::OP_FAST) ? in_data.buttons : held_in;
      b_q <= 4'd0;
      pulse_q <= '0;
    end else begin
      if (cmd.next_b) b_q <= b_q + 4'd1;
      if (cmd.upd && imm_pulse) pulse_q[b_q] <= 1'b1;
      if (cmd.div_step && sts.div_last && rem_next == 16'h0000) pulse_q[b_q] <= 1'b1;
    end
    if (cmd.upd) begin
      div_dq <= d;
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_dq <= {div_dq[14:0], 1'b0};
      div_rem <= rem_next;
      div_cnt <= div_cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CONTROLLERS; i++) prev[i] <= '0;
    end else if (cmd.emit) begin
      prev[c_q[PW-1:0]] <= held_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.port <= c_q;
      out_data.held <= held_q;
      out_data.pressed_edge <= held_q & ~prev[c_q[PW-1:0]];
      out_data.repeat_pulse <= pulse_q;
    end
  end

  always_comb begin
    sts.port_ok = {1'b0, c_q} < NC;
    sts.op_fast = op_q == gpea_pkg::OP_FAST;
    sts.mask_nz = held_q != 16'h0000;
    sts.need_div = hit && ge_delay && d != 16'h0000 && cfg_period != 16'h0000
                   && d >= cfg_period;
    sts.div_last = div_cnt == 4'd15;
    sts.last_b = b_q == 4'd15;
    sts.out_free = !out_valid || out_ready;
  end

endmodule

// File: sv/gpea_ctrl.sv
// Controller: sequences dispatch, per-button counter update, remainder steps and emit.
// Depends on gpea_pkg for the command and status structs.
module gpea_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gpea_pkg::sts_t sts,
  output gpea_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_UPD = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (!sts.port_ok) begin
          state_next = S_IDLE;
        end else if (sts.op_fast) begin
          cmd.fast_wr = sts.mask_nz;
          state_next = S_IDLE;
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (sts.need_div) begin
          state_next = S_DIV;
        end else if (sts.last_b) begin
          state_next = S_EMIT;
        end else begin
          cmd.next_b = 1'b1;
          state_next = S_READ;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          if (sts.last_b) begin
            state_next = S_EMIT;
          end else begin
            cmd.next_b = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/gpea_chk.sv
// Port-level checker for gamepad_edge_and_autorepeat, attached by bind.
// Depends on gpea_pkg for the result struct.
module gpea_chk #(
  parameter int NUM_CONTROLLERS = 4
) (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input gpea_pkg::out_t out_data
);

  localparam logic [2:0] NC = 3'(NUM_CONTROLLERS);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped before transfer");

  a_edge_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.pressed_edge & ~out_data.held) == 16'h0000)
    else $error("pressed edge on a button not held");

  a_pulse_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.repeat_pulse & ~out_data.held) == 16'h0000)
    else $error("repeat pulse on a button not held");

  a_port_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, out_data.port} < NC)
    else $error("result for a controller out of range");

endmodule

bind gamepad_edge_and_autorepeat gpea_chk #(
  .NUM_CONTROLLERS (NUM_CONTROLLERS)
) u_gpea_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/tb_top.sv
// Self-checking testbench for gamepad_edge_and_autorepeat: directed and random frame-sample
// and fast-set transfers under random idling, each report predicted and checked by field.
// Depends on gpea_pkg and the block RTL only.

class autorepeat_scoreboard;
  bit [15:0] delay_reg;
  bit [15:0] period_reg;
  bit [63:0] enable_reg;
  bit        stick_reg;
  bit [15:0] last_held [4];
  bit [15:0] hold_count [64];
  gpea_pkg::out_t expected_reports [$];
  int unsigned errors;

  function new();
    delay_reg = gpea_pkg::DELAY_RESET;
    period_reg = gpea_pkg::PERIOD_RESET;
    enable_reg = '0;
    stick_reg = 1'b0;
    foreach (last_held[i]) last_held[i] = '0;
    foreach (hold_count[i]) hold_count[i] = '0;
    errors = 0;
  endfunction

  function void write_reg(logic [gpea_pkg::CFG_IDX_W-1:0] idx,
                          logic [gpea_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      gpea_pkg::CFG_DELAY: begin
        delay_reg = data[15:0];
      end
      gpea_pkg::CFG_PERIOD: begin
        period_reg = data[15:0];
      end
      gpea_pkg::CFG_ENABLE: begin
        enable_reg = data;
      end
      gpea_pkg::CFG_STICK: begin
        stick_reg = data[0];
      end
      default: begin
      end
    endcase
  endfunction

  function bit [15:0] stick_dirs(logic signed [7:0] sx, logic signed [7:0] sy);
    int x, y, ax, ay;
    bit [15:0] dirs;
    x = int'(sx);
    y = int'(sy);
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    dirs = '0;
    if (ay >= ax) begin
      if (y >= 8) dirs |= gpea_pkg::PAD_UP;
      if (y <= -8) dirs |= gpea_pkg::PAD_DOWN;
    end else begin
      if (x <= -8) dirs |= gpea_pkg::PAD_LEFT;
      if (x >= 8) dirs |= gpea_pkg::PAD_RIGHT;
    end
    return dirs;
  endfunction

  function bit repeat_due(bit [15:0] cnt);
    int unsigned d;
    if (cnt == 16'd1) return 1'b1;
    if (cnt < delay_reg) return 1'b0;
    d = 32'(cnt) - 32'(delay_reg);
    if (period_reg == 16'd0) return d == 0;
    return (d % 32'(period_reg)) == 0;
  endfunction

  function void note_item(gpea_pkg::in_t item);
    int c, b, k;
    bit [15:0] held, rise, pulse, en;
    gpea_pkg::out_t report;
    c = int'(item.controller);
    if (item.operation == gpea_pkg::OP_FAST) begin
      if (item.buttons == '0) return;
      for (b = 0; b < 16; b++) begin
        if (item.buttons[b]) break;
      end
      hold_count[c * 16 + b] = delay_reg + period_reg - 16'd1;
      return;
    end
    held = item.buttons;
    if (stick_reg) held |= stick_dirs(item.stick_x, item.stick_y);
    rise = held & ~last_held[c];
    en = enable_reg[16 * c +: 16];
    pulse = '0;
    for (b = 0; b < 16; b++) begin
      k = c * 16 + b;
      if (en[b] && held[b]) begin
        hold_count[k] += 16'd1;
        pulse[b] = repeat_due(hold_count[k]);
      end else if (en[b]) begin
        hold_count[k] = '0;
      end
    end
    last_held[c] = held;
    report.port = item.controller;
    report.held = held;
    report.pressed_edge = rise;
    report.repeat_pulse = pulse;
    expected_reports.push_back(report);
  endfunction

  function void compare_field(string name, bit [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_report(gpea_pkg::out_t got);
    gpea_pkg::out_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t: report expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = expected_reports.pop_front();
    compare_field("port", 16'(want.port), 16'(got.port));
    compare_field("held", want.held, got.held);
    compare_field("pressed_edge", want.pressed_edge, got.pressed_edge);
    compare_field("repeat_pulse", want.repeat_pulse, got.repeat_pulse);
  endfunction
endclass

module tb_top;

  localparam int IDLE_MAX = 11;
  localparam int DRAIN_CYCLES = 320;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 183;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  gpea_pkg::in_t                       in_data = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  gpea_pkg::out_t                      out_data;
  logic                                cfg_we = 1'b0;
  logic [gpea_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [gpea_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  bit                    tx_gaps = 1'b1;
  bit                    rx_stalls = 1'b1;
  int unsigned           quiet_cycles = 0;
  logic [15:0]           pad_buttons [4] = '{default: '0};
  logic signed [7:0]     pad_x [4] = '{default: '0};
  logic signed [7:0]     pad_y [4] = '{default: '0};

  autorepeat_scoreboard board = new();

  gamepad_edge_and_autorepeat u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) board.note_item(in_data);
    if (!rst && out_valid && out_ready) board.check_report(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("gamepad_edge_and_autorepeat regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned stall;
    @(posedge clk);
    forever begin
      stall = rx_stalls ? $urandom_range(0, IDLE_MAX) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (rst || out_valid !== 1'b1);
    end
  end

  function automatic gpea_pkg::in_t make_item(logic op, int c, int b, int x, int y);
    gpea_pkg::in_t item;
    item.operation = op;
    item.controller = c[1:0];
    item.buttons = b[15:0];
    item.stick_x = x[7:0];
    item.stick_y = y[7:0];
    return item;
  endfunction

  function automatic logic [7:0] random_axis();
    int near [9] = '{-9, -8, -7, 7, 8, 9, 0, -128, 127};
    int pick;
    if ($urandom_range(0, 1) == 1) return 8'($urandom_range(0, 255));
    pick = near[$urandom_range(0, 8)];
    return pick[7:0];
  endfunction

  function automatic logic [15:0] random_span();
    case ($urandom_range(0, 6))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'($urandom_range(1, 8));
      3: return 16'd20;
      4: return 16'hFFFF;
      5: return 16'($urandom_range(1, 65535));
      default: return 16'($urandom_range(2, 40));
    endcase
  endfunction

  task automatic program_reg(logic [gpea_pkg::CFG_IDX_W-1:0] idx,
                             logic [gpea_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, data);
  endtask

  task automatic send_item(gpea_pkg::in_t item);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // hold the sender until every report is in, then let the block go quiet
  task automatic drain_reports(int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (board.expected_reports.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic pick_config(int phase);
    logic [15:0] dly, per;
    logic [63:0] mask;
    logic        stk;
    if (phase == 0) begin
      dly = 16'd1;
      per = 16'd1;
      mask = '1;
      stk = 1'b1;
    end else if (phase == 1) begin
      dly = 16'hFFFF;
      per = 16'hFFFF;
      mask = '1;
      stk = 1'b0;
    end else begin
      dly = random_span();
      per = random_span();
      case ($urandom_range(0, 3))
        0: mask = '1;
        1: mask = {$urandom, $urandom};
        2: begin
          for (int c = 0; c < 4; c++) begin
            case ($urandom_range(0, 2))
              0: mask[16 * c +: 16] = '0;
              1: mask[16 * c +: 16] = '1;
              default: mask[16 * c +: 16] = 16'($urandom);
            endcase
          end
        end
        default: mask = {$urandom & $urandom, $urandom & $urandom};
      endcase
      stk = 1'($urandom_range(0, 1));
    end
    program_reg(gpea_pkg::CFG_DELAY, 64'(dly));
    program_reg(gpea_pkg::CFG_PERIOD, 64'(per));
    program_reg(gpea_pkg::CFG_ENABLE, mask);
    program_reg(gpea_pkg::CFG_STICK, 64'(stk));
  endtask

  task automatic run_phase(int count);
    int c, roll;
    logic [15:0] mask;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        tx_gaps = $urandom_range(0, 2) != 0;
        rx_stalls = $urandom_range(0, 2) != 0;
      end
      if (i == count / 2) drain_reports(0);
      c = $urandom_range(0, 3);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        case ($urandom_range(0, 3))
          0: mask = '0;
          1, 2: mask = 16'd1 << $urandom_range(0, 15);
          default: mask = 16'($urandom);
        endcase
        send_item(make_item(gpea_pkg::OP_FAST, c, int'(mask), $urandom_range(0, 255),
                            $urandom_range(0, 255)));
      end else if (roll < 14) begin
        send_item(make_item(gpea_pkg::OP_SAMPLE, c, $urandom_range(0, 65535),
                            int'(random_axis()), int'(random_axis())));
      end else begin
        if ($urandom_range(0, 99) < 6) begin
          case ($urandom_range(0, 3))
            0: pad_buttons[c] = '0;
            1: pad_buttons[c] ^= 16'd1 << $urandom_range(0, 15);
            2: pad_buttons[c] = 16'($urandom);
            default: pad_buttons[c] = 16'($urandom & $urandom);
          endcase
          pad_x[c] = random_axis();
          pad_y[c] = random_axis();
        end
        send_item(make_item(gpea_pkg::OP_SAMPLE, c, int'(pad_buttons[c]), int'(pad_x[c]),
                            int'(pad_y[c])));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    program_reg(gpea_pkg::CFG_STICK, 64'd1);
    program_reg(gpea_pkg::CFG_DELAY, 64'd3);
    program_reg(gpea_pkg::CFG_PERIOD, 64'd2);
    program_reg(gpea_pkg::CFG_ENABLE, 64'h7FFF_0000_FFFF_FFFF);
    send_item(make_item(gpea_pkg::OP_SAMPLE, 0, 'hFFFF, 0, 0));
    send_item(make_item(gpea_pkg::OP_SAMPLE, 0, 'hFFFF, 0, 0));
    send_item(make_item(gpea_pkg::OP_SAMPLE, 0, 'hFFFF, -128, 127));
    send_item(make_item(gpea_pkg::OP_SAMPLE, 0, 'h0000, 127, 0));
    send_item(make_item(gpea_pkg::OP_SAMPLE, 1, 'h0000, -128, -128));
    send_item(make_item(gpea_pkg::OP_SAMPLE, 1, 'h0000, 7, -7));
    send_item(make_item(gpea_pkg::OP_SAMPLE, 1, 'h0000, -8, 8));
    send_item(make_item(gpea_pkg::OP_SAMPLE, 1, 'h0000, 8, -9));
    send_item(make_item(gpea_pkg::OP_SAMPLE, 2, 'hFFFF, -9, 3));
    send_item(make_item(gpea_pkg::OP_FAST, 0, 'h0000, 0, 0));
    send_item(make_item(gpea_pkg::OP_FAST, 3, 'h8000, 0, 0));
    send_item(make_item(gpea_pkg::OP_FAST, 0, 'hFFFE, 0, 0));
    send_item(make_item(gpea_pkg::OP_SAMPLE, 0, 'h0002, 0, 0));
    send_item(make_item(gpea_pkg::OP_SAMPLE, 3, 'hFFFF, 0, 0));
    drain_reports(DRAIN_CYCLES);

    // zero delay and zero period, then wrap from a fast-set to all ones
    program_reg(gpea_pkg::CFG_DELAY, 64'd0);
    program_reg(gpea_pkg::CFG_PERIOD, 64'd0);
    program_reg(gpea_pkg::CFG_STICK, 64'd0);
    send_item(make_item(gpea_pkg::OP_SAMPLE, 1, 'h5A5A, 127, 127));
    send_item(make_item(gpea_pkg::OP_SAMPLE, 1, 'h5A5A, -128, -128));
    send_item(make_item(gpea_pkg::OP_FAST, 1, 'h0002, 0, 0));
    send_item(make_item(gpea_pkg::OP_SAMPLE, 1, 'h5A5A, 0, 0));
    drain_reports(DRAIN_CYCLES);

    program_reg(gpea_pkg::CFG_PERIOD, 64'd3);
    repeat (3) send_item(make_item(gpea_pkg::OP_SAMPLE, 0, 'h00FF, 0, 0));
    drain_reports(DRAIN_CYCLES);

    program_reg(gpea_pkg::CFG_DELAY, 64'hFFFF);
    program_reg(gpea_pkg::CFG_PERIOD, 64'hFFFF);
    send_item(make_item(gpea_pkg::OP_FAST, 0, 'h0100, 0, 0));
    repeat (3) send_item(make_item(gpea_pkg::OP_SAMPLE, 0, 'h0100, 0, 0));

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_reports(DRAIN_CYCLES);
      pick_config(phase);
      run_phase(PHASE_ITEMS);
    end

    drain_reports(DRAIN_CYCLES);
    if (board.errors == 0) begin
      $display("gamepad_edge_and_autorepeat regression: pass");
    end else begin
      $display("gamepad_edge_and_autorepeat regression: fail");
    end
    $finish;
  end
endmodule

// File: gamepad_edge_and_autorepeat.f
sv/gpea_pkg.sv
sv/gpea_dp.sv
sv/gpea_ctrl.sv
sv/gamepad_edge_and_autorepeat.sv
sv/gpea_chk.sv
tb/tb_top.sv
